[hw/rtl/sfd_pkg.sv]
// shared constants and types of the serial frame deframer
package sfd_pkg;

    localparam int MAX_PAYLOAD = 32;
    localparam int STORE_AW    = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1;
    localparam int LEN_W       = $clog2(MAX_PAYLOAD + 1);

    localparam logic [7:0] START_CODE = 8'h55;
    localparam logic [7:0] STOP_CODE  = 8'hAA;

    typedef enum logic [2:0] {
        ST_DATA     = 3'd0,
        ST_EMPTY    = 3'd1,
        ST_BAD_STOP = 3'd2,
        ST_BAD_SUM  = 3'd3,
        ST_TOO_LONG = 3'd4
    } status_t;

    typedef struct packed {
        logic [7:0]       addr;
        logic [LEN_W-1:0] len;
        status_t          status;
    } cmd_t;

    typedef struct packed {
        logic                en;
        logic [STORE_AW-1:0] addr;
        logic [7:0]          data;
    } store_wr_t;

endpackage

[hw/rtl/sfd_front.sv]
// byte parser: frame recognition, checksum and payload store writes
module sfd_front (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               s_tvalid,
    output logic               s_tready,
    input  logic [7:0]         s_tdata,    // rx_byte
    input  logic               drain_idle,
    input  logic               q_full,
    output logic               q_push,
    output sfd_pkg::cmd_t      q_cmd,
    output sfd_pkg::store_wr_t store_wr
);
    import sfd_pkg::*;

    typedef enum logic [2:0] {
        PH_HUNT,
        PH_ADDR,
        PH_LEN,
        PH_DATA,
        PH_SUM,
        PH_STOP
    } phase_t;

    phase_t              phase_reg, phase_next;
    logic [7:0]          addr_reg, addr_next;
    logic [LEN_W-1:0]    len_reg, len_next;
    logic [STORE_AW-1:0] count_reg, count_next;
    logic [7:0]          sum_reg, sum_next;
    logic [7:0]          chk_reg, chk_next;
    logic                accept;
    logic                stall;

    // hold data bytes back while the previous payload still drains, and length and stop bytes while the queue is full
    assign stall = ((phase_reg == PH_DATA) && !drain_idle)
                || (((phase_reg == PH_LEN) || (phase_reg == PH_STOP)) && q_full);
    assign s_tready = !stall;
    assign accept   = s_tvalid && s_tready;

    always_comb
    begin
        phase_next    = phase_reg;
        addr_next     = addr_reg;
        len_next      = len_reg;
        count_next    = count_reg;
        sum_next      = sum_reg;
        chk_next      = chk_reg;
        q_push        = 1'b0;
        q_cmd.addr    = addr_reg;
        q_cmd.len     = len_reg;
        q_cmd.status  = ST_DATA;
        store_wr.en   = 1'b0;
        store_wr.addr = count_reg;
        store_wr.data = s_tdata;
        if (accept)
        begin
            unique case (phase_reg)
                PH_HUNT:
                begin
                    if (s_tdata == START_CODE)
                    begin
                        phase_next = PH_ADDR;
                    end
                end
                PH_ADDR:
                begin
                    addr_next  = s_tdata;
                    phase_next = PH_LEN;
                end
                PH_LEN:
                begin
                    count_next = '0;
                    sum_next   = '0;
                    if (s_tdata > 8'(MAX_PAYLOAD))
                    begin
                        q_push       = 1'b1;
                        q_cmd.status = ST_TOO_LONG;
                        phase_next   = PH_HUNT;
                    end
                    else
                    begin
                        len_next   = s_tdata[LEN_W-1:0];
                        phase_next = (s_tdata == 8'd0) ? PH_SUM : PH_DATA;
                    end
                end
                PH_DATA:
                begin
                    store_wr.en = 1'b1;
                    sum_next    = sum_reg + s_tdata;
                    if ((LEN_W'(count_reg) + 1'b1) >= len_reg)
                    begin
                        phase_next = PH_SUM;
                    end
                    else
                    begin
                        count_next = count_reg + 1'b1;
                    end
                end
                PH_SUM:
                begin
                    chk_next   = s_tdata;
                    phase_next = PH_STOP;
                end
                PH_STOP:
                begin
                    q_push = 1'b1;
                    if (s_tdata != STOP_CODE)
                    begin
                        q_cmd.status = ST_BAD_STOP;
                    end
                    else if (chk_reg != sum_reg)
                    begin
                        q_cmd.status = ST_BAD_SUM;
                    end
                    else if (len_reg == '0)
                    begin
                        q_cmd.status = ST_EMPTY;
                    end
                    else
                    begin
                        q_cmd.status = ST_DATA;
                    end
                    phase_next = PH_HUNT;
                end
                default:
                begin
                    phase_next = PH_HUNT;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_HUNT;
            addr_reg  <= '0;
            len_reg   <= '0;
            count_reg <= '0;
            sum_reg   <= '0;
            chk_reg   <= '0;
        end
        else
        begin
            phase_reg <= phase_next;
            addr_reg  <= addr_next;
            len_reg   <= len_next;
            count_reg <= count_next;
            sum_reg   <= sum_next;
            chk_reg   <= chk_next;
        end
    end

    // payload writes never overlap a drain of the store
    a_wr_drain_idle: assert property (@(posedge clk) disable iff (!rst_n)
        store_wr.en |-> drain_idle)
        else $error("store written while a drain is in progress");

endmodule

[hw/rtl/sfd_queue.sv]
// two-entry command queue between parser and drain
module sfd_queue (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  sfd_pkg::cmd_t push_cmd,
    output logic          full,
    input  logic          pop,
    output sfd_pkg::cmd_t pop_cmd,
    output logic          empty
);
    import sfd_pkg::*;

    cmd_t       entry_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;

    assign full    = (count_reg == 2'd2);
    assign empty   = (count_reg == 2'd0);
    assign pop_cmd = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg ^ push;
        rd_ptr_next = rd_ptr_reg ^ pop;
        count_next  = count_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_cmd;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> (!full || pop))
        else $error("queue overflow");

    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> !empty)
        else $error("queue underflow");

endmodule

[hw/rtl/sfd_back.sv]
// payload store and result drain with output register
module sfd_back (
    input  logic               clk,
    input  logic               rst_n,
    input  sfd_pkg::store_wr_t store_wr,
    input  logic               q_empty,
    input  sfd_pkg::cmd_t      q_cmd,
    output logic               q_pop,
    output logic               busy,
    output logic               m_tvalid,
    input  logic               m_tready,
    output logic [15:0]        m_tdata,    // slot_address, data_byte
    output logic               m_tlast,
    output logic [2:0]         m_tuser     // status
);
    import sfd_pkg::*;

    typedef enum logic [1:0] {
        DR_IDLE,
        DR_READ,
        DR_LOAD
    } drain_t;

    logic [7:0]          store_mem [MAX_PAYLOAD];
    logic [7:0]          rd_data_reg;
    drain_t              state_reg;
    logic [STORE_AW-1:0] idx_reg;
    logic [LEN_W-1:0]    len_reg;
    logic [7:0]          addr_reg;
    logic                out_valid_reg;
    logic [15:0]         out_data_reg;
    logic                out_last_reg;
    logic [2:0]          out_user_reg;
    logic                slot_free;
    logic                is_last;
    logic                out_load;

    assign slot_free = !out_valid_reg || m_tready;
    assign is_last   = ((LEN_W'(idx_reg) + 1'b1) == len_reg);
    assign busy      = (state_reg != DR_IDLE);
    assign q_pop     = (state_reg == DR_IDLE) && !q_empty
                    && ((q_cmd.status == ST_DATA) || slot_free);
    // output register takes a status result or the next payload byte
    assign out_load  = (q_pop && (q_cmd.status != ST_DATA))
                    || ((state_reg == DR_LOAD) && slot_free);

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tlast  = out_last_reg;
    assign m_tuser  = out_user_reg;

    always_ff @(posedge clk)
    begin
        if (store_wr.en)
        begin
            store_mem[store_wr.addr] <= store_wr.data;
        end
        if (state_reg == DR_READ)
        begin
            rd_data_reg <= store_mem[idx_reg];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= DR_IDLE;
            idx_reg       <= '0;
            len_reg       <= '0;
            addr_reg      <= '0;
            out_valid_reg <= 1'b0;
            out_data_reg  <= '0;
            out_last_reg  <= 1'b0;
            out_user_reg  <= '0;
        end
        else
        begin
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_valid_reg && m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                DR_IDLE:
                begin
                    if (q_pop)
                    begin
                        if (q_cmd.status == ST_DATA)
                        begin
                            addr_reg  <= q_cmd.addr;
                            len_reg   <= q_cmd.len;
                            idx_reg   <= '0;
                            state_reg <= DR_READ;
                        end
                        else
                        begin
                            out_data_reg  <= {8'd0, q_cmd.addr};
                            out_last_reg  <= 1'b1;
                            out_user_reg  <= q_cmd.status;
                        end
                    end
                end
                DR_READ:
                begin
                    state_reg <= DR_LOAD;
                end
                DR_LOAD:
                begin
                    if (slot_free)
                    begin
                        out_data_reg  <= {rd_data_reg, addr_reg};
                        out_last_reg  <= is_last;
                        out_user_reg  <= ST_DATA;
                        if (is_last)
                        begin
                            state_reg <= DR_IDLE;
                        end
                        else
                        begin
                            idx_reg   <= idx_reg + 1'b1;
                            state_reg <= DR_READ;
                        end
                    end
                end
                default:
                begin
                    state_reg <= DR_IDLE;
                end
            endcase
        end
    end

    // drain index stays inside the frame being emitted
    a_idx_in_frame: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != DR_IDLE) |-> (LEN_W'(idx_reg) < len_reg))
        else $error("drain index beyond frame length");

endmodule

[hw/rtl/serial_frame_deframer.sv]
// top level of the serial frame deframer
//
// s_* carries received serial bytes, one request per byte. m_* carries results:
// slot address and payload byte in tdata, status in tuser, tlast on the final
// result of a frame. A good frame gives its payload bytes in order; an empty
// good frame, a bad stop, a bad checksum or an oversized length give one
// status result each.
// Input: one byte per cycle while the parser hunts or reads the header. While
// an earlier payload still drains from the store, payload bytes of the next
// frame are held off by s_tready; stop and length bytes wait only when the
// two-entry command queue is full.
// Results: a status result goes from the command queue straight into the output
// register; each payload byte is read from the store into a read register in
// DR_READ and moved to the output register in DR_LOAD, one byte at a time.
// When m_tready is low the output register holds its result and the drain
// waits; the parser keeps taking header bytes until the queue fills.
// Reset empties the queue, drops any pending result and sends the parser back
// to hunting for the start byte; the store needs no clearing.
module serial_frame_deframer (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // rx_byte
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // slot_address, data_byte
    output logic        m_tlast,
    output logic [2:0]  m_tuser    // status
);
    import sfd_pkg::*;

    cmd_t      push_cmd;
    cmd_t      pop_cmd;
    store_wr_t store_wr;
    logic      q_push;
    logic      q_pop;
    logic      q_full;
    logic      q_empty;
    logic      back_busy;
    logic      drain_idle;

    assign drain_idle = q_empty && !back_busy;

    sfd_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .drain_idle (drain_idle),
        .q_full     (q_full),
        .q_push     (q_push),
        .q_cmd      (push_cmd),
        .store_wr   (store_wr)
    );

    sfd_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (q_push),
        .push_cmd (push_cmd),
        .full     (q_full),
        .pop      (q_pop),
        .pop_cmd  (pop_cmd),
        .empty    (q_empty)
    );

    sfd_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .store_wr (store_wr),
        .q_empty  (q_empty),
        .q_cmd    (pop_cmd),
        .q_pop    (q_pop),
        .busy     (back_busy),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser)
    );

endmodule
